// File: design/lsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED scanner package
// Shared constants, register indexes and field widths for the scanner block.
// ----------------------------------------------------------------------------
package lsp_pkg;

   // Pattern constants (Q8 levels, Q6.18 positions, Q16 brightness)
   localparam int unsigned MAX_LEDS           = 64;
   localparam int unsigned TRAIL_INTENSITY_Q8 = 166;
   localparam int unsigned BACKGROUND_Q8      = 0;
   localparam int unsigned LEADING_BOOST_Q8   = 307;

   localparam int unsigned POS_BITS       = 18;
   localparam int unsigned ONE_Q16        = 65536;
   localparam int unsigned DEFAULT_PERIOD = 2500;

   // Payload widths
   localparam int unsigned NOW_W     = 32;
   localparam int unsigned LED_IDX_W = 6;
   localparam int unsigned CHAN_W    = 8;

   // Shared divider geometry
   localparam int unsigned DIV_NUM_W = 57;
   localparam int unsigned DIV_DEN_W = 25;

   // Config port
   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      CSR_LED_COUNT   = 3'd0,
      CSR_ROUND_MS    = 3'd1,
      CSR_MODE        = 3'd2,
      CSR_PAUSE_MS    = 3'd3,
      CSR_BASE_COLOR  = 3'd4,
      CSR_CORE_WIDTH  = 3'd5,
      CSR_TAIL_LENGTH = 3'd6,
      CSR_TAIL_FADE   = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_BOUNCE = 2'd0,
      MODE_FWD    = 2'd1,
      MODE_BWD    = 2'd2,
      MODE_UNUSED = 2'd3
   } mode_type;

   // Reset values of the config registers
   localparam logic [6:0]  RST_LED_COUNT   = 7'd64;
   localparam logic [15:0] RST_ROUND_MS    = 16'd2500;
   localparam logic [1:0]  RST_MODE        = 2'd0;
   localparam logic [15:0] RST_PAUSE_MS    = 16'd120;
   localparam logic [23:0] RST_BASE_COLOR  = 24'hFF0000;
   localparam logic [7:0]  RST_CORE_WIDTH  = 8'd22;
   localparam logic [3:0]  RST_TAIL_LENGTH = 4'd6;
   localparam logic [8:0]  RST_TAIL_FADE   = 9'd141;

endpackage

// File: design/lsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED scanner channels
// Valid/ready channels for frame tick requests and per-LED color results.
// ----------------------------------------------------------------------------
interface lsp_req_if;
   import lsp_pkg::*;
   logic             valid;
   logic             ready;
   logic [NOW_W-1:0] now_ms;

   modport source (output valid, output now_ms, input ready);
   modport sink   (input valid, input now_ms, output ready);
endinterface

interface lsp_rsp_if;
   import lsp_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [LED_IDX_W-1:0] led_index;
   logic [CHAN_W-1:0]    red;
   logic [CHAN_W-1:0]    green;
   logic [CHAN_W-1:0]    blue;
   logic                 last;

   modport source (output valid, output led_index, output red, output green,
                   output blue, output last, input ready);
   modport sink   (input valid, input led_index, input red, input green,
                   input blue, input last, output ready);
endinterface

// File: design/lsp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED scanner divider
// Restoring radix-2 divider, one quotient bit per cycle, quotient and rest.
// ----------------------------------------------------------------------------
module lsp_div #(
   parameter int unsigned NUM_W = lsp_pkg::DIV_NUM_W,
   parameter int unsigned DEN_W = lsp_pkg::DIV_DEN_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quot,
   output logic [DEN_W-1:0] rem
);
   localparam int unsigned CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quot_ff, quot_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;

   always_comb begin
      trial   = {rem_ff, quot_ff[NUM_W-1]};
      diff    = trial - {1'b0, den_ff};
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start && !run_ff) begin
         quot_in = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = CNT_W'(NUM_W);
         run_in  = 1'b1;
      end else if (run_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in  = diff[DEN_W-1:0];
            quot_in = {quot_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in  = trial[DEN_W-1:0];
            quot_in = {quot_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;
   assign rem  = rem_ff;

endmodule

// File: design/led_scanner_pattern.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED scanner pattern
// Chase pattern generator: per tick, move the scan head, then stream one
// saturated RGB result per driven LED, flagged last on the final LED.
// Head move, when the head moves: two 57-step divisions on the shared
// divider. Per LED, core LEDs take two divisions and tail LEDs a loop of
// multiplies for the fade power.
// Ticks are taken one at a time: a new tick is accepted only back in idle,
// after the last LED of the frame is taken; output stalls hold the frame.
// Reset: synchronous, active high; config to defaults, head at 0, no pause.
// ----------------------------------------------------------------------------
module led_scanner_pattern (
   input  logic                            clock,
   input  logic                            reset,
   lsp_req_if.sink                         req_ch,
   lsp_rsp_if.source                       rsp_ch,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [lsp_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [lsp_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [lsp_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import lsp_pkg::*;

   typedef enum logic [26:0] {
      ST_IDLE       = 27'h0000001,
      ST_STEP_MUL   = 27'h0000002,
      ST_STEP_DIV   = 27'h0000004,
      ST_STEP_WAIT  = 27'h0000008,
      ST_MOD_DIV    = 27'h0000010,
      ST_MOD_WAIT   = 27'h0000020,
      ST_MOVE       = 27'h0000040,
      ST_LED_DIST   = 27'h0000080,
      ST_LED_BASE   = 27'h0000100,
      ST_RATIO_WAIT = 27'h0000200,
      ST_COS_SQ     = 27'h0000400,
      ST_COS_DIV    = 27'h0000800,
      ST_COS_WAIT   = 27'h0001000,
      ST_TAIL_LOOP  = 27'h0002000,
      ST_TAIL_UPD   = 27'h0004000,
      ST_TAIL_Q     = 27'h0008000,
      ST_TAIL_FR    = 27'h0010000,
      ST_TAIL_FADE  = 27'h0020000,
      ST_TRAIL_MUL  = 27'h0040000,
      ST_TRAIL_RES  = 27'h0080000,
      ST_CLAMP      = 27'h0100000,
      ST_BOOST      = 27'h0200000,
      ST_COL_R      = 27'h0400000,
      ST_COL_G      = 27'h0800000,
      ST_COL_B      = 27'h1000000,
      ST_COL_DONE   = 27'h2000000,
      ST_EMIT       = 27'h4000000
   } state_type;

   localparam logic [16:0] ONE17 = 17'(ONE_Q16);
   localparam logic [16:0] BG17  = 17'(BACKGROUND_Q8 << 8);
   localparam logic [16:0] TI17  = 17'(TRAIL_INTENSITY_Q8);
   localparam logic [16:0] LB17  = 17'(LEADING_BOOST_Q8);
   localparam logic        BOOST_ON = (LEADING_BOOST_Q8 > 256);

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   // config
   logic [6:0]  led_count_ff, led_count_in;
   logic [15:0] round_ms_ff, round_ms_in;
   logic [1:0]  mode_ff, mode_in;
   logic [15:0] pause_ms_ff, pause_ms_in;
   logic [23:0] color_ff, color_in;
   logic [7:0]  core_ff, core_in;
   logic [3:0]  tail_len_ff, tail_len_in;
   logic [8:0]  tail_fade_ff, tail_fade_in;
   // scan state
   logic [23:0] scan_ff, scan_in;
   logic        down_ff, down_in;
   logic [31:0] last_tick_ff, last_tick_in;
   logic [31:0] pause_end_ff, pause_end_in;
   // sequencer and work registers
   state_type   state_ff, state_in;
   logic [31:0] now_ff, now_in;
   logic [31:0] delta_ff, delta_in;
   logic [6:0]  n_ff, n_in;
   logic [5:0]  i_ff, i_in;
   logic [56:0] d_ff, d_in;
   logic [24:0] dm_ff, dm_in;
   logic [24:0] dist_ff, dist_in;
   logic        boost_ff, boost_in;
   logic [16:0] p_ff, p_in;
   logic [16:0] q_ff, q_in;
   logic [3:0]  k_ff, k_in;
   logic [3:0]  ip_ff, ip_in;
   logic [15:0] fr_ff, fr_in;
   logic [16:0] fade_ff, fade_in;
   logic [16:0] b_ff, b_in;
   logic [7:0]  red_ff, red_in;
   logic [7:0]  green_ff, green_in;
   logic [7:0]  blue_ff, blue_in;
   logic [48:0] mul_ff, mul_in;

   // ---------------------------------------------------------------------
   // Shared divider
   // ---------------------------------------------------------------------
   logic                 div_start;
   logic [DIV_NUM_W-1:0] div_num;
   logic [DIV_DEN_W-1:0] div_den;
   logic                 div_done;
   logic [DIV_NUM_W-1:0] div_quot;
   logic [DIV_DEN_W-1:0] div_rem;

   lsp_div #(
      .NUM_W (DIV_NUM_W),
      .DEN_W (DIV_DEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot),
      .rem   (div_rem)
   );

   // ---------------------------------------------------------------------
   // Helpers
   // ---------------------------------------------------------------------
   function automatic logic [16:0] clamp_lvl(input logic [16:0] v);
      logic [16:0] r;
      r = v;
      if (r < BG17) r = BG17;
      if (r > ONE17) r = ONE17;
      return r;
   endfunction

   function automatic logic [7:0] sat8(input logic [48:0] prod);
      logic [7:0] r;
      r = (|prod[48:24]) ? 8'hFF : prod[23:16];
      return r;
   endfunction

   // Derived config values
   logic        cyc;
   logic [6:0]  n_eff;
   logic [15:0] period_eff;
   logic [20:0] hc;
   logic [24:0] circ;
   logic [24:0] m_len;
   logic [24:0] per;
   logic [7:0]  speed;

   assign cyc        = (mode_ff == MODE_FWD) || (mode_ff == MODE_BWD);
   assign n_eff      = (led_count_ff > 7'(MAX_LEDS)) ? 7'(MAX_LEDS) : led_count_ff;
   assign period_eff = (round_ms_ff == '0) ? 16'(DEFAULT_PERIOD) : round_ms_ff;
   assign hc         = {core_ff, 13'd0};
   assign circ       = {n_ff, 18'd0};
   assign m_len      = {n_ff - 7'd1, 18'd0};
   assign per        = {m_len[23:0], 1'b0};
   // LEDs swept per round: n around a ring, 2(n-1) for a bounce round trip
   assign speed      = cyc ? {1'b0, n_ff} : {n_ff - 7'd1, 1'b0};

   // APB: always ready, writes complete in the access phase
   logic        csr_wr;
   logic [2:0]  csr_idx;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[4:2];

   always_comb begin
      case (csr_index_type'(csr_idx))
         CSR_LED_COUNT:   csr_prdata = 32'(led_count_ff);
         CSR_ROUND_MS:    csr_prdata = 32'(round_ms_ff);
         CSR_MODE:        csr_prdata = 32'(mode_ff);
         CSR_PAUSE_MS:    csr_prdata = 32'(pause_ms_ff);
         CSR_BASE_COLOR:  csr_prdata = 32'(color_ff);
         CSR_CORE_WIDTH:  csr_prdata = 32'(core_ff);
         CSR_TAIL_LENGTH: csr_prdata = 32'(tail_len_ff);
         CSR_TAIL_FADE:   csr_prdata = 32'(tail_fade_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // Handshakes
   assign req_ch.ready     = (state_ff == ST_IDLE);
   assign rsp_ch.valid     = (state_ff == ST_EMIT);
   assign rsp_ch.led_index = i_ff;
   assign rsp_ch.red       = red_ff;
   assign rsp_ch.green     = green_ff;
   assign rsp_ch.blue      = blue_ff;
   assign rsp_ch.last      = ({1'b0, i_ff} == (n_ff - 7'd1));

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   logic [31:0] tick_delta;
   logic [24:0] pos_c, p_b, qq_b, t_c;
   logic [25:0] q_b, t_sum;
   logic        hit_b;
   logic [23:0] idx, direct;
   logic [24:0] wrap, dist_c, td;
   logic signed [25:0] ahead;
   logic [16:0] x2, b_c, mul_a17;
   logic [31:0] mul_a;
   logic [16:0] mul_b;
   logic [16:0] f16;
   logic [16:0] lvl;

   always_comb begin
      // defaults: hold
      led_count_in = led_count_ff;
      round_ms_in  = round_ms_ff;
      mode_in      = mode_ff;
      pause_ms_in  = pause_ms_ff;
      color_in     = color_ff;
      core_in      = core_ff;
      tail_len_in  = tail_len_ff;
      tail_fade_in = tail_fade_ff;
      scan_in      = scan_ff;
      down_in      = down_ff;
      last_tick_in = last_tick_ff;
      pause_end_in = pause_end_ff;
      state_in     = state_ff;
      now_in       = now_ff;
      delta_in     = delta_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      d_in         = d_ff;
      dm_in        = dm_ff;
      dist_in      = dist_ff;
      boost_in     = boost_ff;
      p_in         = p_ff;
      q_in         = q_ff;
      k_in         = k_ff;
      ip_in        = ip_ff;
      fr_in        = fr_ff;
      fade_in      = fade_ff;
      b_in         = b_ff;
      red_in       = red_ff;
      green_in     = green_ff;
      blue_in      = blue_ff;
      div_start    = 1'b0;
      div_num      = '0;
      div_den      = '0;
      mul_a        = '0;
      mul_b        = '0;

      tick_delta = '0;
      pos_c  = '0; p_b = '0; qq_b = '0; t_c = '0; q_b = '0; t_sum = '0;
      hit_b  = 1'b0;
      idx    = '0; direct = '0; wrap = '0; dist_c = '0; td = '0;
      ahead  = '0;
      x2     = '0; b_c = '0; mul_a17 = '0;
      f16    = {1'b0, tail_fade_ff[7:0], 8'd0};
      lvl    = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid && led_count_ff != '0) begin
               // time since the last tick, frozen while an edge pause runs
               tick_delta = (last_tick_ff == '0) ? '0 : req_ch.now_ms - last_tick_ff;
               if (pause_end_ff != '0) begin
                  if (req_ch.now_ms < pause_end_ff) tick_delta = '0;
                  else pause_end_in = '0;
               end
               last_tick_in = req_ch.now_ms;
               now_in       = req_ch.now_ms;
               delta_in     = tick_delta;
               n_in         = n_eff;
               i_in         = '0;
               if (tick_delta == '0) begin
                  state_in = ST_LED_DIST;
               end else if (!cyc && n_eff == 7'd1) begin
                  scan_in  = '0;
                  state_in = ST_LED_DIST;
               end else begin
                  state_in = ST_STEP_MUL;
               end
            end
         end
         ST_STEP_MUL: begin
            mul_a    = delta_ff;
            mul_b    = 17'(speed);
            state_in = ST_STEP_DIV;
         end
         ST_STEP_DIV: begin
            // step = speed * delta * 2^18 / period
            div_start = 1'b1;
            div_num   = {mul_ff[38:0], 18'd0};
            div_den   = 25'(period_eff);
            state_in  = ST_STEP_WAIT;
         end
         ST_STEP_WAIT: begin
            if (div_done) begin
               d_in     = div_quot;
               state_in = ST_MOD_DIV;
            end
         end
         ST_MOD_DIV: begin
            div_start = 1'b1;
            div_num   = d_ff;
            div_den   = cyc ? circ : per;
            state_in  = ST_MOD_WAIT;
         end
         ST_MOD_WAIT: begin
            if (div_done) begin
               dm_in    = div_rem;
               state_in = ST_MOVE;
            end
         end
         ST_MOVE: begin
            if (cyc) begin
               if (mode_ff == MODE_BWD) t_sum = {2'd0, scan_ff} + {1'b0, circ} - {1'b0, dm_ff};
               else                     t_sum = {2'd0, scan_ff} + {1'b0, dm_ff};
               t_c = (t_sum >= {1'b0, circ}) ? 25'(t_sum - {1'b0, circ}) : t_sum[24:0];
               scan_in = t_c[23:0];
               down_in = (mode_ff == MODE_BWD);
            end else begin
               // fold the move onto one round of the triangle path
               pos_c = ({1'b0, scan_ff} > m_len) ? m_len : {1'b0, scan_ff};
               if (down_ff) p_b = (pos_c == '0) ? '0 : per - pos_c;
               else         p_b = pos_c;
               q_b   = {1'b0, p_b} + {1'b0, dm_ff};
               hit_b = (d_ff >= 57'(per)) || (p_b < m_len && q_b >= {1'b0, m_len})
                       || (q_b >= {1'b0, per});
               qq_b  = (q_b >= {1'b0, per}) ? 25'(q_b - {1'b0, per}) : q_b[24:0];
               if (d_ff != '0) begin
                  if (qq_b >= m_len) begin
                     scan_in = 24'(per - qq_b);
                     down_in = 1'b1;
                  end else begin
                     scan_in = qq_b[23:0];
                     down_in = 1'b0;
                  end
                  if (hit_b && pause_ms_ff != '0) pause_end_in = now_ff + 32'(pause_ms_ff);
               end
            end
            state_in = ST_LED_DIST;
         end
         ST_LED_DIST: begin
            idx    = {i_ff, 18'd0};
            direct = (idx >= scan_ff) ? idx - scan_ff : scan_ff - idx;
            wrap   = (circ > {1'b0, direct}) ? circ - {1'b0, direct} : '0;
            dist_c = (cyc && wrap < {1'b0, direct}) ? wrap : {1'b0, direct};
            dist_in = dist_c;
            // leading boost window: just ahead of the head in travel direction
            ahead = down_ff ? $signed({2'd0, scan_ff}) - $signed({2'd0, idx})
                            : $signed({2'd0, idx}) - $signed({2'd0, scan_ff});
            if (cyc && ahead < 0) ahead = ahead + $signed({1'b0, circ});
            boost_in = BOOST_ON && (hc != '0) && (ahead >= 0)
                       && (ahead <= $signed(26'(hc) + 26'(1 << (POS_BITS - 1))));
            state_in = ST_LED_BASE;
         end
         ST_LED_BASE: begin
            td = dist_ff - 25'(hc);
            if (hc != '0 && dist_ff <= 25'(hc)) begin
               // core: ratio x = d / half core in Q16
               div_start = 1'b1;
               div_num   = 57'({dist_ff, 16'd0});
               div_den   = 25'(hc);
               state_in  = ST_RATIO_WAIT;
            end else if (hc == '0 && dist_ff == '0) begin
               b_in     = ONE17;
               state_in = ST_CLAMP;
            end else if (td <= 25'({tail_len_ff, 18'd0})) begin
               ip_in = td[21:18];
               fr_in = td[17:2];
               if (tail_fade_ff == '0) begin
                  fade_in  = (td == '0) ? ONE17 : '0;
                  state_in = ST_TRAIL_MUL;
               end else if (tail_fade_ff[8]) begin
                  fade_in  = ONE17;
                  state_in = ST_TRAIL_MUL;
               end else begin
                  p_in     = ONE17;
                  k_in     = '0;
                  state_in = ST_TAIL_LOOP;
               end
            end else begin
               b_in     = BG17;
               state_in = ST_CLAMP;
            end
         end
         ST_RATIO_WAIT: begin
            if (div_done) begin
               p_in     = (div_quot > 57'(ONE17)) ? ONE17 : div_quot[16:0];
               state_in = ST_COS_SQ;
            end
         end
         ST_COS_SQ: begin
            mul_a    = 32'(p_ff);
            mul_b    = p_ff;
            state_in = ST_COS_DIV;
         end
         ST_COS_DIV: begin
            // cos approx: 4(1 - x^2) / (4 + x^2), Q16
            x2        = mul_ff[32:16];
            div_start = 1'b1;
            div_num   = 57'({ONE17 - x2, 18'd0});
            div_den   = 25'(19'h40000 + 19'(x2));
            state_in  = ST_COS_WAIT;
         end
         ST_COS_WAIT: begin
            if (div_done) begin
               b_in     = div_quot[16:0];
               state_in = ST_CLAMP;
            end
         end
         ST_TAIL_LOOP: begin
            mul_a = 32'(p_ff);
            mul_b = f16;
            if (k_ff < ip_ff) state_in = ST_TAIL_UPD;
            else              state_in = ST_TAIL_Q;
         end
         ST_TAIL_UPD: begin
            p_in     = mul_ff[32:16];
            k_in     = k_ff + 4'd1;
            state_in = ST_TAIL_LOOP;
         end
         ST_TAIL_Q: begin
            q_in     = mul_ff[32:16];
            state_in = ST_TAIL_FR;
         end
         ST_TAIL_FR: begin
            // linear blend between fade^k and fade^(k+1)
            mul_a    = 32'(p_ff - q_ff);
            mul_b    = {1'b0, fr_ff};
            state_in = ST_TAIL_FADE;
         end
         ST_TAIL_FADE: begin
            fade_in  = p_ff - mul_ff[32:16];
            state_in = ST_TRAIL_MUL;
         end
         ST_TRAIL_MUL: begin
            mul_a    = 32'(fade_ff);
            mul_b    = TI17;
            state_in = ST_TRAIL_RES;
         end
         ST_TRAIL_RES: begin
            b_in     = mul_ff[24:8];
            state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            b_c  = clamp_lvl(b_ff);
            b_in = b_c;
            if (boost_ff) begin
               mul_a    = 32'(b_c);
               mul_b    = LB17;
               state_in = ST_BOOST;
            end else begin
               state_in = ST_COL_R;
            end
         end
         ST_BOOST: begin
            b_in     = clamp_lvl(mul_ff[24:8]);
            state_in = ST_COL_R;
         end
         ST_COL_R: begin
            mul_a    = 32'(color_ff[23:16]);
            mul_b    = b_ff;
            state_in = ST_COL_G;
         end
         ST_COL_G: begin
            red_in   = sat8(mul_ff);
            mul_a    = 32'(color_ff[15:8]);
            mul_b    = b_ff;
            state_in = ST_COL_B;
         end
         ST_COL_B: begin
            green_in = sat8(mul_ff);
            mul_a    = 32'(color_ff[7:0]);
            mul_b    = b_ff;
            state_in = ST_COL_DONE;
         end
         ST_COL_DONE: begin
            blue_in  = sat8(mul_ff);
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_ch.ready) begin
               if ({1'b0, i_ff} == (n_ff - 7'd1)) begin
                  state_in = ST_IDLE;
               end else begin
                  i_in     = i_ff + 6'd1;
                  state_in = ST_LED_DIST;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Config write: restarts position and timing; the host must write only
      // while no tick is in flight, which the block itself does not enforce
      if (csr_wr) begin
         case (csr_index_type'(csr_idx))
            CSR_LED_COUNT:   led_count_in = csr_pwdata[6:0];
            CSR_ROUND_MS:    round_ms_in  = csr_pwdata[15:0];
            CSR_MODE:        mode_in      = csr_pwdata[1:0];
            CSR_PAUSE_MS:    pause_ms_in  = csr_pwdata[15:0];
            CSR_BASE_COLOR:  color_in     = csr_pwdata[23:0];
            CSR_CORE_WIDTH:  core_in      = csr_pwdata[7:0];
            CSR_TAIL_LENGTH: tail_len_in  = csr_pwdata[3:0];
            CSR_TAIL_FADE:   tail_fade_in = csr_pwdata[8:0];
            default:         led_count_in = led_count_ff;
         endcase
         scan_in      = '0;
         down_in      = (mode_in == MODE_BWD);
         last_tick_in = '0;
         pause_end_in = '0;
      end

      // shared multiplier, registered
      mul_a17 = mul_b;
      mul_in  = 49'(mul_a) * 49'(mul_a17);
      lvl     = b_ff;
   end

   always_ff @(posedge clock) begin
      now_ff   <= now_in;
      delta_ff <= delta_in;
      n_ff     <= n_in;
      i_ff     <= i_in;
      d_ff     <= d_in;
      dm_ff    <= dm_in;
      dist_ff  <= dist_in;
      boost_ff <= boost_in;
      p_ff     <= p_in;
      q_ff     <= q_in;
      k_ff     <= k_in;
      ip_ff    <= ip_in;
      fr_ff    <= fr_in;
      fade_ff  <= fade_in;
      b_ff     <= (state_ff == ST_IDLE) ? lvl : b_in;
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
      mul_ff   <= mul_in;
      if (reset) begin
         led_count_ff <= RST_LED_COUNT;
         round_ms_ff  <= RST_ROUND_MS;
         mode_ff      <= RST_MODE;
         pause_ms_ff  <= RST_PAUSE_MS;
         color_ff     <= RST_BASE_COLOR;
         core_ff      <= RST_CORE_WIDTH;
         tail_len_ff  <= RST_TAIL_LENGTH;
         tail_fade_ff <= RST_TAIL_FADE;
         scan_ff      <= '0;
         down_ff      <= 1'b0;
         last_tick_ff <= '0;
         pause_end_ff <= '0;
         state_ff     <= ST_IDLE;
      end else begin
         led_count_ff <= led_count_in;
         round_ms_ff  <= round_ms_in;
         mode_ff      <= mode_in;
         pause_ms_ff  <= pause_ms_in;
         color_ff     <= color_in;
         core_ff      <= core_in;
         tail_len_ff  <= tail_len_in;
         tail_fade_ff <= tail_fade_in;
         scan_ff      <= scan_in;
         down_ff      <= down_in;
         last_tick_ff <= last_tick_in;
         pause_end_ff <= pause_end_in;
         state_ff     <= state_in;
      end
   end

endmodule

// File: tb/sv/led_scanner_pattern_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED scanner pattern testbench
// Sends frame ticks and register settings to the scanner. A frame predictor
// computes every LED color of each accepted tick, and each color returned by
// the block is checked in order against it. Both channels stall in bursts.
// ----------------------------------------------------------------------------

import lsp_pkg::*;

typedef struct packed {
   bit [5:0] led;
   bit [7:0] red;
   bit [7:0] green;
   bit [7:0] blue;
   bit       last;
} led_color_type;

// Frame predictor plus the queue of LED colors still owed by the block
class lsp_frame_scoreboard;
   bit [6:0]   led_count = RST_LED_COUNT;
   bit [15:0]  period_ms = RST_ROUND_MS;
   bit [1:0]   mode      = RST_MODE;
   bit [15:0]  pause_ms  = RST_PAUSE_MS;
   bit [23:0]  color     = RST_BASE_COLOR;
   bit [7:0]   core_w    = RST_CORE_WIDTH;
   bit [3:0]   tail_len  = RST_TAIL_LENGTH;
   bit [8:0]   fade_q8   = RST_TAIL_FADE;
   bit [31:0]  head_pos;
   bit         down;
   bit [31:0]  last_tick;
   bit [31:0]  pause_end;
   led_color_type owed[$];
   int         errors;

   function void write_reg(csr_index_type idx, bit [31:0] v);
      case (idx)
         CSR_LED_COUNT:   led_count = v[6:0];
         CSR_ROUND_MS:    period_ms = v[15:0];
         CSR_MODE:        mode      = v[1:0];
         CSR_PAUSE_MS:    pause_ms  = v[15:0];
         CSR_BASE_COLOR:  color     = v[23:0];
         CSR_CORE_WIDTH:  core_w    = v[7:0];
         CSR_TAIL_LENGTH: tail_len  = v[3:0];
         CSR_TAIL_FADE:   fade_q8   = v[8:0];
         default: ;
      endcase
      head_pos  = 0;
      down      = (mode == MODE_BWD);
      last_tick = 0;
      pause_end = 0;
   endfunction

   // Rational cosine approximation, Q16 in and out
   function longint unsigned cosine(longint unsigned x);
      longint unsigned x2;
      if (x > ONE_Q16) x = ONE_Q16;
      x2 = (x * x) >> 16;
      return ((4 * (ONE_Q16 - x2)) << 16) / (4 * ONE_Q16 + x2);
   endfunction

   // Core or tail level for distance d from the head, half core hc
   function longint unsigned level(longint unsigned d, longint unsigned hc);
      longint unsigned bg, b, td, fade, f16, ip, fr, p, q;
      bg = longint'(BACKGROUND_Q8) << 8;
      b  = bg;
      if (hc > 0 && d <= hc) begin
         b = cosine((d << 16) / hc);
      end else if (hc == 0 && d == 0) begin
         b = ONE_Q16;
      end else begin
         td = (d > hc) ? d - hc : 0;
         if (td <= (longint'(tail_len) << POS_BITS)) begin
            if (fade_q8 == 0) begin
               fade = (td == 0) ? ONE_Q16 : 0;
            end else if (fade_q8 >= 256) begin
               fade = ONE_Q16;
            end else begin
               f16 = longint'(fade_q8) << 8;
               ip  = td >> POS_BITS;
               fr  = (td & ((64'd1 << POS_BITS) - 1)) >> (POS_BITS - 16);
               p   = ONE_Q16;
               for (int k = 0; k < ip && k < 16; k++) p = (p * f16) >> 16;
               q    = (p * f16) >> 16;
               fade = p - (((p - q) * fr) >> 16);
            end
            b = (fade * TRAIL_INTENSITY_Q8) >> 8;
         end
      end
      if (b < bg) b = bg;
      if (b > ONE_Q16) b = ONE_Q16;
      return b;
   endfunction

   // Advance the head for one accepted tick and queue the frame's colors
   function void note_tick(bit [31:0] now);
      bit [31:0] n, delta, period;
      bit cyc, hit;
      longint unsigned hc, circ, d, pos, m, per, p, q, b, bg, v, direct, wrap;
      longint idx, spos, ahead, max_ahead;
      bit [7:0] ch [3];
      led_color_type c;
      n = led_count;
      period = (period_ms != 0) ? period_ms : DEFAULT_PERIOD;
      cyc = (mode == MODE_FWD || mode == MODE_BWD);
      hc = longint'(core_w) << (POS_BITS - 5);
      bg = longint'(BACKGROUND_Q8) << 8;
      if (n == 0) return;
      if (n > MAX_LEDS) n = MAX_LEDS;
      circ = longint'(n) << POS_BITS;

      delta = (last_tick == 0) ? 0 : now - last_tick;
      last_tick = now;
      if (pause_end != 0) begin
         if (now < pause_end) delta = 0;
         else pause_end = 0;
      end

      if (delta != 0) begin
         if (cyc) begin
            d = ((longint'(n) * delta) << POS_BITS) / period;
            pos = head_pos % circ;
            d = d % circ;
            down = (mode == MODE_BWD);
            pos = down ? (pos + circ - d) % circ : (pos + d) % circ;
            head_pos = pos;
         end else if (n <= 1) begin
            head_pos = 0;
         end else begin
            m   = longint'(n - 1) << POS_BITS;
            per = 2 * m;
            d   = ((longint'(2 * (n - 1)) * delta) << POS_BITS) / period;
            pos = head_pos;
            if (pos > m) pos = m;
            p   = down ? (per - pos) % per : pos;
            q   = p + d % per;
            hit = (d >= per) || (p < m && q >= m) || (q >= per);
            if (q >= per) q -= per;
            if (d != 0) begin
               if (q >= m) begin
                  head_pos = per - q;
                  down = 1;
               end else begin
                  head_pos = q;
                  down = 0;
               end
               if (hit && pause_ms > 0) pause_end = now + pause_ms;
            end
         end
      end

      ch[0] = color[23:16];
      ch[1] = color[15:8];
      ch[2] = color[7:0];
      for (int i = 0; i < n; i++) begin
         idx  = longint'(i) << POS_BITS;
         spos = head_pos;
         direct = (idx >= spos) ? idx - spos : spos - idx;
         d = direct;
         if (cyc) begin
            wrap = (circ > direct) ? circ - direct : 0;
            if (wrap < direct) d = wrap;
         end
         b = level(d, hc);
         if (LEADING_BOOST_Q8 > 256 && hc > 0) begin
            max_ahead = hc + (64'd1 << (POS_BITS - 1));
            ahead = down ? spos - idx : idx - spos;
            if (cyc && ahead < 0) ahead += circ;
            if (ahead >= 0 && ahead <= max_ahead) b = (b * LEADING_BOOST_Q8) >> 8;
         end
         if (b < bg) b = bg;
         if (b > ONE_Q16) b = ONE_Q16;
         c.led = 6'(i);
         v = (ch[0] * b) >> 16; c.red   = (v > 255) ? 8'd255 : v[7:0];
         v = (ch[1] * b) >> 16; c.green = (v > 255) ? 8'd255 : v[7:0];
         v = (ch[2] * b) >> 16; c.blue  = (v > 255) ? 8'd255 : v[7:0];
         c.last = (i == n - 1);
         owed.push_back(c);
      end
   endfunction

   function void check_color(led_color_type got);
      led_color_type exp_c;
      if (owed.size() == 0) begin
         $display("%0t: unexpected LED color idx=%0d rgb=%h%h%h last=%0d", $time,
                  got.led, got.red, got.green, got.blue, got.last);
         errors++;
         return;
      end
      exp_c = owed.pop_front();
      if (exp_c != got) begin
         $display("%0t: LED color mismatch: expected idx=%0d rgb=%h%h%h last=%0d,",
                  $time, exp_c.led, exp_c.red, exp_c.green, exp_c.blue, exp_c.last);
         $display("   actual idx=%0d rgb=%h%h%h last=%0d",
                  got.led, got.red, got.green, got.blue, got.last);
         errors++;
      end
   endfunction
endclass

module led_scanner_pattern_tb;
   logic        clock = 0;
   logic        reset = 1;
   logic        csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   lsp_req_if req_bus ();
   lsp_rsp_if rsp_bus ();

   lsp_frame_scoreboard frames = new();

   bit          quiet = 0;     // no idling on either side in the final part
   bit [31:0]   tick_ms;       // running timestamp for well-formed tick streams

   led_scanner_pattern dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_bus.sink),
      .rsp_ch      (rsp_bus.source),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   initial begin
      req_bus.valid  = 0;
      req_bus.now_ms = '0;
   end

   // Result side: ready drops in random bursts, changes at the falling edge
   initial begin
      int stall;
      stall = 0;
      rsp_bus.ready = 0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            rsp_bus.ready = 0;
            stall--;
         end else begin
            rsp_bus.ready = 1;
            if (!quiet && $urandom_range(0, 9) == 0) stall = $urandom_range(1, 19);
         end
      end
   end

   // Every accepted LED color is checked against the oldest owed one
   always @(posedge clock) begin
      led_color_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.led   = rsp_bus.led_index;
         got.red   = rsp_bus.red;
         got.green = rsp_bus.green;
         got.blue  = rsp_bus.blue;
         got.last  = rsp_bus.last;
         frames.check_color(got);
      end
   end

   // APB write: setup cycle, then access cycle; pready is always high
   task automatic csr_write(csr_index_type idx, bit [31:0] v);
      @(negedge clock);
      csr_psel    = 1;
      csr_penable = 0;
      csr_pwrite  = 1;
      csr_paddr   = 5'(idx) << 2;
      csr_pwdata  = v;
      @(negedge clock);
      csr_penable = 1;
      do @(posedge clock); while (!csr_pready);
      frames.write_reg(idx, v);
      @(negedge clock);
      csr_psel    = 0;
      csr_penable = 0;
      csr_pwrite  = 0;
   endtask

   // One tick request; valid stays high across back-to-back requests
   task automatic send_tick(bit [31:0] now);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_bus.valid = 0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_bus.valid  = 1;
      req_bus.now_ms = now;
      do @(posedge clock); while (!req_bus.ready);
      frames.note_tick(now);
   endtask

   // Wait until the block is done with everything sent so far
   task automatic drain();
      @(negedge clock);
      req_bus.valid = 0;
      while (frames.owed.size() != 0) @(posedge clock);
      // a zero-LED tick leaves nothing owed; the block drops it while idle
      repeat (300) @(negedge clock);
   endtask

   task automatic setup(bit [6:0] n, bit [15:0] period, mode_type md, bit [15:0] pause,
                        bit [23:0] rgb, bit [7:0] core, bit [3:0] tail, bit [8:0] fade);
      csr_write(CSR_LED_COUNT, n);
      csr_write(CSR_ROUND_MS, period);
      csr_write(CSR_MODE, md);
      csr_write(CSR_PAUSE_MS, pause);
      csr_write(CSR_BASE_COLOR, rgb);
      csr_write(CSR_CORE_WIDTH, core);
      csr_write(CSR_TAIL_LENGTH, tail);
      csr_write(CSR_TAIL_FADE, fade);
   endtask

   // Mostly steadily advancing timestamps, with repeats, zeros and wild jumps
   task automatic random_ticks(int count);
      int sel;
      for (int k = 0; k < count; k++) begin
         sel = $urandom_range(0, 19);
         if (sel < 16)
            tick_ms = tick_ms + $urandom_range(0, frames.period_ms / 4 + 3);
         else if (sel == 16) tick_ms = tick_ms;
         else if (sel == 17) tick_ms = 0;
         else tick_ms = $urandom;
         send_tick(tick_ms);
      end
   endtask

   initial begin
      bit [6:0]  n;
      bit [15:0] period, pause;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Reset defaults: first tick, small step, bounce into the far end, ticks
      // inside the edge pause, then the top of the time range and a wrap
      send_tick(0);
      send_tick(7);
      send_tick(8);
      send_tick(1258);
      send_tick(1300);
      send_tick(1400);
      send_tick(32'hFFFF_FFFF);
      send_tick(3);
      drain();

      // Single LED bouncing with the longest pause
      setup(1, 100, MODE_BOUNCE, 16'hFFFF, 24'hFFFFFF, 8'd255, 4'd15, 9'd141);
      send_tick(10);
      send_tick(500);
      drain();

      // No LEDs: nothing comes back
      setup(0, 100, MODE_BOUNCE, 16'd5, 24'h808080, 8'd22, 4'd6, 9'd141);
      send_tick(5);
      send_tick(6);
      drain();

      // Oversized count, unused mode, default period, hard tail cut, no pause
      setup(7'd127, 16'd0, MODE_UNUSED, 16'd0, 24'hFFFFFF, 8'd255, 4'd15, 9'd0);
      send_tick(1);
      send_tick(2000);
      send_tick(40000);
      drain();

      // Forward ring with the fastest period: huge steps wrap many times
      setup(5, 16'd1, MODE_FWD, 16'd0, 24'h123456, 8'd0, 4'd0, 9'd256);
      send_tick(1);
      send_tick(4);
      send_tick(1000000);
      drain();

      // Backward ring with the slowest period, fade field all ones
      setup(7, 16'hFFFF, MODE_BWD, 16'd50, 24'h00FF7F, 8'd8, 4'd3, 9'h1FF);
      send_tick(1);
      send_tick(30000);
      send_tick(90000);
      drain();

      // Bounce, fastest period: one tick spans several round trips
      setup(4, 16'd1, MODE_BOUNCE, 16'd3, 24'hA5A5A5, 8'd40, 4'd2, 9'd200);
      send_tick(1);
      send_tick(2);
      send_tick(9);
      drain();

      // Random settings; the last phase runs without idling
      for (int ph = 0; ph < 8; ph++) begin
         case ($urandom_range(0, 7))
            0:       n = 64;
            1:       n = 7'($urandom_range(0, 127));
            default: n = 7'($urandom_range(1, 16));
         endcase
         period = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 400));
         pause  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 60));
         setup(n, period, mode_type'($urandom_range(0, 3)), pause, 24'($urandom),
               8'($urandom), 4'($urandom), 9'($urandom));
         if (ph == 7) quiet = 1;
         tick_ms = $urandom;
         random_ticks(12);
         drain();
      end

      if (frames.errors == 0 && frames.owed.size() == 0) begin
         $display("** led_scanner_pattern: PASSED **");
      end else begin
         if (frames.owed.size() != 0)
            $display("%0t: %0d LED colors never arrived", $time, frames.owed.size());
         $display("** led_scanner_pattern: FAILED **");
      end
      $finish;
   end

   // Watchdog: far above the slowest legal run
   initial begin
      #60_000_000;
      $display("%0t: timeout", $time);
      $display("** led_scanner_pattern: FAILED **");
      $finish;
   end
endmodule
